// ----- rtl/core/rmf_pkg.sv -----
// Shared types and constants for the RGB median filter.
// No dependencies; used by the top level, datapath and controller by scoped name.
`default_nettype none
package rmf_pkg;

  // Frame height limit and derived widths
  localparam int unsigned MAX_HEIGHT = 1024;
  localparam int unsigned ROW_W      = 10;
  localparam int unsigned PEND_W     = 16;
  localparam logic [PEND_W-1:0] PEND_MAX = '1;

  // Configuration register indexes
  localparam logic [1:0] CFG_WINDOW_SIZE  = 2'd0;
  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd2;

  // Input beat kinds
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GATHER,
    ST_FLUSH,
    ST_SELECT,
    ST_DELIVER
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic gather_first;
    logic gather_step;
    logic sel_step;
    logic deliver;
  } ctl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic emit;
    logic gather_last;
    logic sel_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ----- rtl/core/rgb_median_filter.sv -----
// RGB median filter: one pixel beat a cycle when it yields no result.
// A beat that yields a result runs n*n line store reads, one read flush,
// n*n rank-selection steps and one deliver, which waits for a free output register.
// The single-read store port and the one-candidate select loop set these steps.
// Reset is asynchronous, active low: counters and window are cleared, config goes
// to its defaults (window 3, 640 by 480), the line store is not reset.
`default_nettype none
module rgb_median_filter #(
  parameter int unsigned MAX_WINDOW = 7,
  parameter int unsigned MAX_WIDTH  = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [10:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        action_i,
  input  wire logic [7:0]  red_in_i,
  input  wire logic [7:0]  green_in_i,
  input  wire logic [7:0]  blue_in_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       red_out_o,
  output logic [7:0]       green_out_o,
  output logic [7:0]       blue_out_o,
  output logic             frame_end_o
);

  rmf_pkg::ctl_t ctl;
  rmf_pkg::sts_t sts;
  logic          cfg_we;

  // Config beats land only while the controller is idle
  assign cfg_we = cfg_valid_i && cfg_ready_o;

  rmf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cfg_ready_o(cfg_ready_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  rmf_datapath #(
    .MAX_WINDOW(MAX_WINDOW),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_we),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .action_i   (action_i),
    .red_in_i   (red_in_i),
    .green_in_i (green_in_i),
    .blue_in_i  (blue_in_i),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .red_out_o  (red_out_o),
    .green_out_o(green_out_o),
    .blue_out_o (blue_out_o),
    .frame_end_o(frame_end_o),
    .ctl_i      (ctl),
    .sts_o      (sts)
  );

endmodule
`default_nettype wire

// ----- rtl/core/rmf_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none
module rmf_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 8192
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- rtl/core/rmf_datapath.sv -----
// Datapath: config registers, position counters, line store, window
// gather and rank selection, output register. Uses rmf_pkg and rmf_ram.
`default_nettype none
module rmf_datapath #(
  parameter int unsigned MAX_WINDOW = 7,
  parameter int unsigned MAX_WIDTH  = 1024
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  input  wire logic [1:0]        cfg_index_i,
  input  wire logic [10:0]       cfg_data_i,
  input  wire logic              action_i,
  input  wire logic [7:0]        red_in_i,
  input  wire logic [7:0]        green_in_i,
  input  wire logic [7:0]        blue_in_i,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  output logic [7:0]             red_out_o,
  output logic [7:0]             green_out_o,
  output logic [7:0]             blue_out_o,
  output logic                   frame_end_o,
  input  wire rmf_pkg::ctl_t     ctl_i,
  output rmf_pkg::sts_t          sts_o
);

  localparam int unsigned ROW_SLOTS = MAX_WINDOW + 1;
  localparam int unsigned WIN_CELLS = MAX_WINDOW * MAX_WINDOW;
  localparam int unsigned DEPTH     = ROW_SLOTS * MAX_WIDTH;
  localparam int unsigned AW        = $clog2(DEPTH);
  localparam int unsigned COL_W     = $clog2(MAX_WIDTH);
  localparam int unsigned SLOT_W    = $clog2(ROW_SLOTS);
  localparam int unsigned OFS_W     = $clog2(MAX_WINDOW + 1) + 1;
  localparam int unsigned IDX_W     = $clog2(WIN_CELLS + 1);
  localparam int unsigned CELL_W    = (WIN_CELLS > 1) ? $clog2(WIN_CELLS) : 1;

  // Configuration registers
  logic [2:0]  win_q;
  logic [10:0] wid_q, hei_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= 3'd3;
      wid_q <= 11'd640;
      hei_q <= 11'd480;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rmf_pkg::CFG_WINDOW_SIZE:  win_q <= cfg_data_i[2:0];
        rmf_pkg::CFG_IMAGE_WIDTH:  wid_q <= cfg_data_i;
        rmf_pkg::CFG_IMAGE_HEIGHT: hei_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective window, size, radius and lag
  int unsigned n_e, w_e, h_e, r_e, k_e, lag_e;

  always_comb begin
    n_e = int'(win_q);
    if (n_e > MAX_WINDOW) n_e = MAX_WINDOW;
    if (n_e[0] == 1'b0) n_e = (n_e == 0) ? 1 : n_e - 1;
    w_e = int'(wid_q);
    if (w_e == 0) w_e = 1;
    if (w_e > MAX_WIDTH) w_e = MAX_WIDTH;
    h_e = int'(hei_q);
    if (h_e == 0) h_e = 1;
    if (h_e > rmf_pkg::MAX_HEIGHT) h_e = rmf_pkg::MAX_HEIGHT;
    r_e   = (n_e - 1) >> 1;
    k_e   = n_e * n_e;
    lag_e = r_e * w_e + r_e;
  end

  // Input and output positions, pending count
  logic [COL_W-1:0]          in_col_q, out_col_q;
  logic [rmf_pkg::ROW_W-1:0] in_row_q, out_row_q;
  logic [SLOT_W-1:0]         in_slot_q, out_slot_q;
  logic [rmf_pkg::PEND_W-1:0] pend_q, pend_inc;
  logic                      is_pixel;

  assign is_pixel = (action_i == rmf_pkg::ACT_PIXEL);
  assign pend_inc = (pend_q == rmf_pkg::PEND_MAX) ? pend_q : pend_q + 1'b1;

  // A pixel emits once past the lag; a drain only at frame start with work pending
  assign sts_o.emit = is_pixel ? (int'(pend_inc) > lag_e)
                               : ((pend_q != '0) && (in_col_q == '0) && (in_row_q == '0));

  logic                      in_wrap, out_wrap;
  assign in_wrap  = (int'(in_col_q) + 1 >= w_e);
  assign out_wrap = (int'(out_col_q) + 1 >= w_e);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_slot_q  <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_slot_q <= '0;
      pend_q     <= '0;
    end else begin
      if (ctl_i.accept && is_pixel) begin
        pend_q <= pend_inc;
        if (in_wrap) begin
          in_col_q  <= '0;
          in_slot_q <= (int'(in_slot_q) == ROW_SLOTS - 1) ? '0 : in_slot_q + 1'b1;
          in_row_q  <= (int'(in_row_q) + 1 >= h_e) ? '0 : in_row_q + 1'b1;
        end else begin
          in_col_q <= in_col_q + 1'b1;
        end
      end
      if (ctl_i.deliver) begin
        pend_q <= pend_q - 1'b1;
        if (out_wrap) begin
          out_col_q  <= '0;
          out_slot_q <= (int'(out_slot_q) == ROW_SLOTS - 1) ? '0 : out_slot_q + 1'b1;
          out_row_q  <= (int'(out_row_q) + 1 >= h_e) ? '0 : out_row_q + 1'b1;
        end else begin
          out_col_q <= out_col_q + 1'b1;
        end
      end
    end
  end

  // Window gather: offsets walk the n by n square
  logic signed [OFS_W-1:0] gdr_q, gdc_q, r_s;
  logic [IDX_W-1:0]        gidx_q;
  logic                    rd_v_q, rd_zero_q;
  logic [IDX_W-1:0]        rd_idx_q;
  int                      rr, cc, sl;
  logic                    g_zero;
  logic [AW-1:0]           raddr, waddr;
  logic [23:0]             rdata;

  assign r_s = OFS_W'(r_e);
  assign sts_o.gather_last = (gdr_q == r_s) && (gdc_q == r_s);

  always_comb begin
    rr = int'(out_row_q) + int'(gdr_q);
    cc = int'(out_col_q) + int'(gdc_q);
    sl = int'(out_slot_q) + int'(ROW_SLOTS) + int'(gdr_q);
    if (sl >= int'(ROW_SLOTS)) sl = sl - int'(ROW_SLOTS);
    if (sl >= int'(ROW_SLOTS)) sl = sl - int'(ROW_SLOTS);
    g_zero = !(rr >= 0 && rr < int'(h_e) && cc >= 0 && cc < int'(w_e));
    raddr  = g_zero ? '0 : AW'(sl * int'(MAX_WIDTH) + cc);
    waddr  = AW'(int'(in_slot_q) * int'(MAX_WIDTH) + int'(in_col_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0;
    end else begin
      rd_v_q <= ctl_i.gather_step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.gather_first) begin
      gdr_q  <= -r_s;
      gdc_q  <= -r_s;
      gidx_q <= '0;
    end else if (ctl_i.gather_step) begin
      gidx_q <= gidx_q + 1'b1;
      if (gdc_q == r_s) begin
        gdc_q <= -r_s;
        gdr_q <= gdr_q + 1'b1;
      end else begin
        gdc_q <= gdc_q + 1'b1;
      end
    end
    rd_zero_q <= g_zero;
    rd_idx_q  <= gidx_q;
  end

  rmf_ram #(
    .WIDTH(24),
    .DEPTH(DEPTH)
  ) u_line_store (
    .clk_i  (clk_i),
    .we_i   (ctl_i.accept && is_pixel),
    .waddr_i(waddr),
    .wdata_i({red_in_i, green_in_i, blue_in_i}),
    .re_i   (ctl_i.gather_step),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Window registers
  logic [23:0] win_cell_q [WIN_CELLS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WIN_CELLS; i++) win_cell_q[i] <= '0;
    end else if (rd_v_q) begin
      win_cell_q[CELL_W'(rd_idx_q)] <= rd_zero_q ? 24'd0 : rdata;
    end
  end

  // Rank selection: one candidate a cycle against all window samples
  logic [IDX_W-1:0] si_q;
  logic [23:0]      cand;
  logic [7:0]       med_q [3];
  int unsigned      lt [3];
  int unsigned      eq [3];
  int unsigned      mid;

  assign cand = win_cell_q[CELL_W'(si_q)];
  assign sts_o.sel_last = (int'(si_q) == int'(k_e) - 1);

  always_comb begin
    mid = (k_e - 1) >> 1;
    for (int c = 0; c < 3; c++) begin
      lt[c] = 0;
      eq[c] = 0;
      for (int j = 0; j < WIN_CELLS; j++) begin
        if (j < int'(k_e)) begin
          if (win_cell_q[j][8*(2-c) +: 8] < cand[8*(2-c) +: 8]) lt[c] = lt[c] + 1;
          if (win_cell_q[j][8*(2-c) +: 8] == cand[8*(2-c) +: 8]) eq[c] = eq[c] + 1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.gather_first) begin
      si_q <= '0;
    end else if (ctl_i.sel_step) begin
      si_q <= si_q + 1'b1;
      for (int c = 0; c < 3; c++) begin
        if (lt[c] <= mid && lt[c] + eq[c] > mid) med_q[c] <= cand[8*(2-c) +: 8];
      end
    end
  end

  // Output register
  logic       ov_q, fe_q;
  logic [7:0] ro_q, go_q, bo_q;

  assign sts_o.out_free = !ov_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (ctl_i.deliver) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.deliver) begin
      ro_q <= med_q[0];
      go_q <= med_q[1];
      bo_q <= med_q[2];
      fe_q <= (int'(out_row_q) == int'(h_e) - 1) && (int'(out_col_q) == int'(w_e) - 1);
    end
  end

  assign out_valid_o = ov_q;
  assign red_out_o   = ro_q;
  assign green_out_o = go_q;
  assign blue_out_o  = bo_q;
  assign frame_end_o = fe_q;

endmodule
`default_nettype wire

// ----- rtl/core/rmf_ctrl.sv -----
// Controller state machine: sequences accept, gather, select and deliver.
// Uses rmf_pkg.
`default_nettype none
module rmf_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               cfg_ready_o,
  input  wire rmf_pkg::sts_t sts_i,
  output rmf_pkg::ctl_t      ctl_o
);

  rmf_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= rmf_pkg::ST_IDLE;
    else state_q <= state_d;
  end

  // Next state and commands; config taken only when idle with no input beat
  always_comb begin
    state_d     = state_q;
    ctl_o       = '0;
    in_ready_o  = 1'b0;
    cfg_ready_o = 1'b0;
    unique case (state_q)
      rmf_pkg::ST_IDLE: begin
        in_ready_o  = 1'b1;
        cfg_ready_o = !in_valid_i;
        if (in_valid_i) begin
          ctl_o.accept = 1'b1;
          if (sts_i.emit) begin
            ctl_o.gather_first = 1'b1;
            state_d = rmf_pkg::ST_GATHER;
          end
        end
      end
      rmf_pkg::ST_GATHER: begin
        ctl_o.gather_step = 1'b1;
        if (sts_i.gather_last) state_d = rmf_pkg::ST_FLUSH;
      end
      rmf_pkg::ST_FLUSH: state_d = rmf_pkg::ST_SELECT;
      rmf_pkg::ST_SELECT: begin
        ctl_o.sel_step = 1'b1;
        if (sts_i.sel_last) state_d = rmf_pkg::ST_DELIVER;
      end
      rmf_pkg::ST_DELIVER: begin
        if (sts_i.out_free) begin
          ctl_o.deliver = 1'b1;
          state_d = rmf_pkg::ST_IDLE;
        end
      end
      default: state_d = rmf_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/core/rmf_checker.sv -----
// Port-level checker for the RGB median filter, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module rmf_props (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       cfg_valid_i,
  input wire logic       cfg_ready_o,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] red_out_o,
  input wire logic       frame_end_o
);

  // Held result keeps its valid, red value and frame end flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(red_out_o) && $stable(frame_end_o))
    else $error("output beat dropped or changed while stalled");

  // Config and input beats never land in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cfg_valid_i && cfg_ready_o && in_valid_i && in_ready_o))
    else $error("config beat taken alongside an input beat");

  // Input side closes only after taking a beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(in_valid_i))
    else $error("input ready fell without a beat");

  // A new result only appears after a busy cycle on the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without processing");

endmodule

bind rgb_median_filter rmf_props u_rmf_props (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .cfg_valid_i(cfg_valid_i),
  .cfg_ready_o(cfg_ready_o),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .red_out_o  (red_out_o),
  .frame_end_o(frame_end_o)
);
`default_nettype wire

// ----- verif/rmf_checker.sv -----
// Checker for the RGB median filter: watches cfg, pixel and result channels.
// It predicts each result and compares it. Depends on rmf_pkg only.
`timescale 1ns / 1ps
module rmf_checker #(
  parameter int unsigned MAX_WINDOW = 7,
  parameter int unsigned MAX_WIDTH  = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        action_i,
  input  logic [7:0]  red_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  blue_in_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  red_out_i,
  input  logic [7:0]  green_out_i,
  input  logic [7:0]  blue_out_i,
  input  logic        frame_end_i,
  output int          errors_o,
  output int          outstanding_o
);

  localparam int unsigned SLOTS = MAX_WINDOW + 1;
  localparam int unsigned CELLS = MAX_WINDOW * MAX_WINDOW;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } pix_out_t;

  typedef logic [7:0] samples_t [CELLS];

  pix_out_t    medians_q[$];
  logic [23:0] line_mem [SLOTS*MAX_WIDTH];
  logic [2:0]  win_raw;
  logic [10:0] width_raw, height_raw;
  int unsigned in_col, in_row, in_slot, out_col, out_row, out_slot, backlog;
  int          errors;

  assign errors_o = errors;

  function automatic int unsigned eff_win();
    int unsigned n;
    n = (win_raw > MAX_WINDOW) ? MAX_WINDOW : win_raw;
    if (n % 2 == 0) n = (n == 0) ? 1 : n - 1;
    return n;
  endfunction

  function automatic int unsigned eff_wid();
    if (width_raw == 0) return 1;
    return (width_raw > MAX_WIDTH) ? MAX_WIDTH : width_raw;
  endfunction

  function automatic int unsigned eff_hgt();
    if (height_raw == 0) return 1;
    return (height_raw > rmf_pkg::MAX_HEIGHT) ? rmf_pkg::MAX_HEIGHT : height_raw;
  endfunction

  // Middle ranked value of the first cnt samples
  function automatic logic [7:0] mid_rank(samples_t s, int cnt);
    logic [7:0] t;
    for (int i = 1; i < cnt; i++) begin
      t = s[i];
      for (int j = i; j > 0 && s[j-1] > t; j--) begin
        s[j] = s[j-1];
        s[j-1] = t;
      end
    end
    return s[(cnt-1)/2];
  endfunction

  task automatic step_pos(inout int unsigned col, inout int unsigned row,
                          inout int unsigned slot);
    col++;
    if (col >= eff_wid()) begin
      col  = 0;
      slot = (slot + 1) % SLOTS;
      row++;
      if (row >= eff_hgt()) row = 0;
    end
  endtask

  // Gather the window round the output position and queue its medians
  task automatic queue_median();
    samples_t   rs, gs, bs;
    pix_out_t   p;
    logic [23:0] px;
    int r, k, rr, cc;
    r = (eff_win() - 1) / 2;
    k = 0;
    for (int dr = -r; dr <= r; dr++) begin
      for (int dc = -r; dc <= r; dc++) begin
        rr = int'(out_row) + dr;
        cc = int'(out_col) + dc;
        px = '0;
        if (rr >= 0 && rr < int'(eff_hgt()) && cc >= 0 && cc < int'(eff_wid()))
          px = line_mem[((int'(out_slot) + SLOTS + dr) % SLOTS) * MAX_WIDTH + cc];
        rs[k] = px[23:16];
        gs[k] = px[15:8];
        bs[k] = px[7:0];
        k++;
      end
    end
    p.red       = mid_rank(rs, k);
    p.green     = mid_rank(gs, k);
    p.blue      = mid_rank(bs, k);
    p.frame_end = (out_row == eff_hgt() - 1) && (out_col == eff_wid() - 1);
    medians_q.push_back(p);
    step_pos(out_col, out_row, out_slot);
    backlog--;
  endtask

  task automatic report(string what, int got, int want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned r, col;
    pix_out_t    e;
    if (!rst_ni) begin
      medians_q.delete();
      foreach (line_mem[i]) line_mem[i] = '0;
      win_raw = 3; width_raw = 640; height_raw = 480;
      in_col = 0; in_row = 0; in_slot = 0;
      out_col = 0; out_row = 0; out_slot = 0;
      backlog = 0;
      errors = 0;
    end else begin
      // result beat against the oldest prediction
      if (out_valid_i && out_ready_i) begin
        if (medians_q.size() == 0) begin
          report("unexpected result beat", 1, 0);
        end else begin
          e = medians_q.pop_front();
          if (red_out_i !== e.red) report("red", red_out_i, e.red);
          if (green_out_i !== e.green) report("green", green_out_i, e.green);
          if (blue_out_i !== e.blue) report("blue", blue_out_i, e.blue);
          if (frame_end_i !== e.frame_end) report("frame_end", frame_end_i, e.frame_end);
        end
      end
      // register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          rmf_pkg::CFG_WINDOW_SIZE:  win_raw = cfg_data_i[2:0];
          rmf_pkg::CFG_IMAGE_WIDTH:  width_raw = cfg_data_i;
          rmf_pkg::CFG_IMAGE_HEIGHT: height_raw = cfg_data_i;
          default: ;
        endcase
      end
      // pixel or drain beat
      if (in_valid_i && in_ready_i) begin
        if (action_i == rmf_pkg::ACT_DRAIN) begin
          if (backlog > 0 && in_col == 0 && in_row == 0) queue_median();
        end else begin
          r   = (eff_win() - 1) / 2;
          col = (in_col < MAX_WIDTH) ? in_col : MAX_WIDTH - 1;
          line_mem[in_slot*MAX_WIDTH + col] = {red_in_i, green_in_i, blue_in_i};
          step_pos(in_col, in_row, in_slot);
          if (backlog < 16'hFFFF) backlog++;
          if (backlog > r * eff_wid() + r) queue_median();
        end
      end
    end
    outstanding_o = medians_q.size();
  end

endmodule

// ----- verif/tb_top.sv -----
// Testbench top for the RGB median filter: clock, reset, stimulus and verdict.
// Depends on rmf_pkg, rgb_median_filter and rmf_checker.
`timescale 1ns / 1ps
module tb_top;

  localparam int QUIET_LIMIT = 20000;
  localparam int SETTLE      = 150;

  logic        clk, rst_n;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  logic [10:0] cfg_data;
  logic        in_valid, in_ready, action;
  logic [7:0]  red_in, green_in, blue_in;
  logic        out_valid, out_ready;
  logic [7:0]  red_out, green_out, blue_out;
  logic        frame_end;
  int          errors, outstanding;
  int          send_idle_pct, recv_idle_pct, pixels_sent;
  logic        hold_req, stim_done;

  rgb_median_filter u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .action_i(action), .red_in_i(red_in), .green_in_i(green_in), .blue_in_i(blue_in),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .red_out_o(red_out), .green_out_o(green_out), .blue_out_o(blue_out),
    .frame_end_o(frame_end)
  );

  rmf_checker u_chk (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .action_i(action), .red_in_i(red_in), .green_in_i(green_in), .blue_in_i(blue_in),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .red_out_i(red_out), .green_out_i(green_out), .blue_out_i(blue_out),
    .frame_end_i(frame_end),
    .errors_o(errors), .outstanding_o(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: random back-pressure, plus one long hold-off on request
  initial begin
    int hold_left;
    logic held;
    hold_left = 0;
    held = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready = 1'b0;
      end else begin
        out_ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: cycles with no beat accepted on any channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
          || !stim_done)
        quiet = ((in_valid && in_ready) || (out_valid && out_ready)
                 || (cfg_valid && cfg_ready)) ? 0 : quiet + 1;
      else
        quiet++;
    end
    $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_beat(logic act, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid = 1'b1;
    action   = act;
    red_in   = r;
    green_in = g;
    blue_in  = b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (act == rmf_pkg::ACT_PIXEL) pixels_sent++;
  endtask

  task automatic send_pixel();
    case ($urandom_range(7))
      0:       send_beat(rmf_pkg::ACT_PIXEL, 8'h00, 8'h00, 8'h00);
      1:       send_beat(rmf_pkg::ACT_PIXEL, 8'hFF, 8'hFF, 8'hFF);
      default: send_beat(rmf_pkg::ACT_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
    endcase
  endtask

  // Registers change only once every predicted result is out and the
  // block has had time to finish any work that yields nothing
  task automatic write_reg(logic [1:0] idx, logic [10:0] val);
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // One whole frame: pixels with stray drains, then drains for the tail
  task automatic run_frame(logic [2:0] win, logic [10:0] wid, logic [10:0] hgt,
                           int drain_pct);
    int n, w, h, r, tail;
    write_reg(rmf_pkg::CFG_WINDOW_SIZE, 11'(win));
    write_reg(rmf_pkg::CFG_IMAGE_WIDTH, wid);
    write_reg(rmf_pkg::CFG_IMAGE_HEIGHT, hgt);
    n = (win % 2 == 0) ? ((win == 0) ? 1 : win - 1) : win;
    w = (wid == 0) ? 1 : ((wid > 1024) ? 1024 : wid);
    h = (hgt == 0) ? 1 : ((hgt > rmf_pkg::MAX_HEIGHT) ? rmf_pkg::MAX_HEIGHT : hgt);
    r = (n - 1) / 2;
    for (int i = 0; i < w * h; i++) begin
      if ($urandom_range(99) < drain_pct)
        send_beat(rmf_pkg::ACT_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
      send_pixel();
    end
    tail = r * w + r;
    if (tail > w * h) tail = w * h;
    tail += $urandom_range(0, 2);
    repeat (tail) send_beat(rmf_pkg::ACT_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  initial begin
    logic [10:0] wid, hgt;
    rst_n = 1'b0;
    cfg_valid = 1'b0; cfg_index = rmf_pkg::CFG_WINDOW_SIZE; cfg_data = '0;
    in_valid = 1'b0; action = rmf_pkg::ACT_PIXEL;
    red_in = '0; green_in = '0; blue_in = '0;
    send_idle_pct = 30; recv_idle_pct = 58;
    pixels_sent = 0; hold_req = 1'b0; stim_done = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: drain with nothing pending, reset config frame start
    send_beat(rmf_pkg::ACT_DRAIN, 8'hFF, 8'h00, 8'hFF);
    run_frame(3'd3, 11'd4, 11'd3, 20);
    run_frame(3'd1, 11'd3, 11'd2, 0);
    run_frame(3'd0, 11'd0, 11'd0, 50);
    run_frame(3'd2, 11'd2, 11'd2, 0);
    run_frame(3'd7, 11'd3, 11'd3, 10);

    // long receiver hold-off while pixels keep coming
    hold_req = 1'b1;
    run_frame(3'd3, 11'd16, 11'd4, 0);

    // random frames under three idling regimes
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 30 : ((ph == 1) ? 58 : 0);
      recv_idle_pct = (ph == 0) ? 58 : ((ph == 1) ? 30 : 0);
      while (pixels_sent < 100 + 170 * (ph + 1)) begin
        wid = ($urandom_range(15) == 0) ? 11'd0 : 11'($urandom_range(1, 12));
        hgt = ($urandom_range(15) == 0) ? 11'd0 : 11'($urandom_range(1, 8));
        run_frame(3'($urandom_range(0, 7)), wid, hgt, $urandom_range(0, 15));
      end
    end

    // over-range width and height, single-pixel window: a short stretch of pixels
    write_reg(rmf_pkg::CFG_WINDOW_SIZE, 11'd1);
    write_reg(rmf_pkg::CFG_IMAGE_WIDTH, 11'd2047);
    write_reg(rmf_pkg::CFG_IMAGE_HEIGHT, 11'd2047);
    repeat (40) send_pixel();

    in_valid = 1'b0;
    stim_done = 1'b1;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/rmf_pkg.sv
rtl/core/rmf_ram.sv
rtl/core/rmf_datapath.sv
rtl/core/rmf_ctrl.sv
rtl/core/rgb_median_filter.sv
rtl/core/rmf_checker.sv
verif/rmf_checker.sv
verif/tb_top.sv
